[src/particle_lifetime_update_macros.svh]
// Assertion helpers shared by the particle update RTL.
`ifndef PARTICLE_LIFETIME_UPDATE_MACROS_SVH
`define PARTICLE_LIFETIME_UPDATE_MACROS_SVH
`ifndef SYNTH
`define PLU_ASSERT(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("particle update check failed");
`define PLU_ASSERT_IMPL(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("particle update check failed");
`define PLU_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("particle update check failed");
`else
`define PLU_ASSERT(lbl, expr)
`define PLU_ASSERT_IMPL(lbl, pre, post)
`define PLU_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

[src/plu_pkg.sv]
package plu_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int QBITS         = 14;
    localparam int ALPHA_SHIFT   = 15;

    // Shared multiplier geometry: operand widths and digit size
    localparam int MUL_AW = 41;
    localparam int MUL_BW = 36;
    localparam int MUL_DW = 4;

    // Item kinds
    localparam logic [1:0] FUNC_TICK   = 2'd0;
    localparam logic [1:0] FUNC_SPAWN  = 2'd1;
    localparam logic [1:0] FUNC_KILL   = 2'd2;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    // Register indexes
    localparam logic [1:0] CFG_VEL_X   = 2'd0;
    localparam logic [1:0] CFG_VEL_Y   = 2'd1;
    localparam logic [1:0] CFG_VEL_Z   = 2'd2;
    localparam logic [1:0] CFG_ANG_VEL = 2'd3;

    // Quaternion component selectors
    localparam logic [1:0] QC_W = 2'd0;
    localparam logic [1:0] QC_X = 2'd1;
    localparam logic [1:0] QC_Y = 2'd2;
    localparam logic [1:0] QC_Z = 2'd3;

    typedef logic [3:0] t_pair;   // {first selector, second selector}

    // Order of the ten quaternion products
    function automatic t_pair plu_qpair(input logic [3:0] k);
        t_pair p;
        case (k)
            4'd0:    p = {QC_W, QC_W};
            4'd1:    p = {QC_X, QC_X};
            4'd2:    p = {QC_Y, QC_Y};
            4'd3:    p = {QC_Z, QC_Z};
            4'd4:    p = {QC_X, QC_Y};
            4'd5:    p = {QC_X, QC_Z};
            4'd6:    p = {QC_Y, QC_Z};
            4'd7:    p = {QC_W, QC_X};
            4'd8:    p = {QC_W, QC_Y};
            4'd9:    p = {QC_W, QC_Z};
            default: p = {QC_W, QC_W};
        endcase
        return p;
    endfunction

    // Matrix entry walk: {row, column} for each of the nine products
    function automatic logic [3:0] plu_rowcol(input logic [3:0] idx);
        logic [3:0] rc;
        case (idx)
            4'd0:    rc = {2'd0, 2'd0};
            4'd1:    rc = {2'd0, 2'd1};
            4'd2:    rc = {2'd0, 2'd2};
            4'd3:    rc = {2'd1, 2'd0};
            4'd4:    rc = {2'd1, 2'd1};
            4'd5:    rc = {2'd1, 2'd2};
            4'd6:    rc = {2'd2, 2'd0};
            4'd7:    rc = {2'd2, 2'd1};
            4'd8:    rc = {2'd2, 2'd2};
            default: rc = {2'd0, 2'd0};
        endcase
        return rc;
    endfunction

endpackage

[src/plu_mul.sv]
// Signed radix-16 serial multiplier: one digit of B per cycle.
module plu_mul #(
    parameter int AW = plu_pkg::MUL_AW,
    parameter int BW = plu_pkg::MUL_BW,
    parameter int DW = plu_pkg::MUL_DW
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [AW-1:0] i_a,
    input  logic signed [BW-1:0] i_b,
    output logic                 o_done,
    output logic [AW+BW-1:0]     o_prod
);
    localparam int ND   = BW / DW;
    localparam int CW   = $clog2(ND);
    localparam int ACCW = AW + DW + 1;

    logic signed [AW-1:0]   r_a;
    logic signed [BW-1:0]   r_b;
    logic signed [ACCW-1:0] r_acc;
    logic [BW-1:0]          r_lo;
    logic [CW-1:0]          r_cnt;
    logic                   r_busy;
    logic                   r_done;

    logic                   last;
    logic signed [DW:0]     dig;
    logic signed [ACCW-1:0] pp;
    logic signed [ACCW-1:0] sum;
    logic [ACCW+BW-1:0]     full;

    // Top digit carries the sign of B
    always_comb begin
        last = (r_cnt == CW'(ND - 1));
        dig  = last ? {r_b[DW-1], r_b[DW-1:0]} : {1'b0, r_b[DW-1:0]};
        pp   = r_a * dig;
        sum  = r_acc + pp;
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    // Accumulate one digit and shift the finished low bits out
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
            r_lo  <= '0;
        end else if (r_busy) begin
            r_b   <= r_b >>> DW;
            r_acc <= sum >>> DW;
            r_lo  <= {sum[DW-1:0], r_lo[BW-1:DW]};
        end
    end

    assign full   = {r_acc, r_lo};
    assign o_prod = full[AW+BW-1:0];
    assign o_done = r_done;

endmodule

[src/plu_div.sv]
// Restoring divider, one quotient bit per cycle; expects i_num <= i_den.
module plu_div #(
    parameter int QW = 17
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [31:0]   i_num,
    input  logic [31:0]   i_den,
    output logic          o_done,
    output logic [QW-1:0] o_quot
);
    localparam int CW = $clog2(QW);

    logic [32:0]   r_rem;
    logic [31:0]   r_den;
    logic [QW-1:0] r_quot;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [32:0]   trial;
    logic          ge;
    logic [32:0]   rem_next;

    // First step compares the numerator itself, later ones the doubled remainder
    always_comb begin
        trial    = (r_cnt == '0) ? r_rem : {r_rem[31:0], 1'b0};
        ge       = (trial >= {1'b0, r_den});
        rem_next = ge ? (trial - {1'b0, r_den}) : trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CW'(QW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= {1'b0, i_num};
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= rem_next;
            r_quot <= {r_quot[QW-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

[src/particle_lifetime_update.sv]
// Channel   | Direction | Payload
// s_axis    | in        | tuser: func; tdata: time, quaternion, spawn fields
// m_axis    | out       | tdata: particle state after the item
// cfg       | in        | write enable, index, 32-bit data (velocity, spin rate)
//
// A live tick runs 25 products through the shared radix-16 multiplier,
// the life division running alongside.
// Spawn, kill, ticks on a dead or spent particle and unused codes skip the multiplier.
// Reset is synchronous and clears the particle and the registers to zero.
// A finished item waits in the output register while the next item is taken;
// the next item stalls in its last cycle only if that register is still full.
`include "particle_lifetime_update_macros.svh"
module particle_lifetime_update #(
    parameter int FRAC_BITS = plu_pkg::FRAC_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // time_value[31:0], quat_w[47:32], quat_x[63:48], quat_y[79:64], quat_z[95:80],
    // spawn_pos_x[127:96], spawn_pos_y[159:128], spawn_pos_z[191:160],
    // spawn_size[223:192], spawn_grow[255:224], spawn_angle[287:256]
    input  logic [287:0] i_s_axis_tdata,
    // func[1:0]
    input  logic [1:0]   i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // alive[0], pos_x[32:1], pos_y[64:33], pos_z[96:65], alpha[112:97],
    // angle[144:113], size[176:145], zero fill above
    output logic [183:0] o_m_axis_tdata,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [31:0]  i_cfg_data
);
    import plu_pkg::*;

    localparam int DIV_K  = (FRAC_BITS > ALPHA_SHIFT) ? FRAC_BITS : ALPHA_SHIFT;
    localparam int DIV_QW = DIV_K + 1;
    localparam int PW     = MUL_AW + MUL_BW;
    localparam int FW     = FRAC_BITS + 34;
    localparam logic [FRAC_BITS:0] LIFE_ONE   = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [15:0]        ALPHA_FULL = 16'h8000;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_MSTART = 2'd1;
    localparam logic [1:0] S_MWAIT  = 2'd2;
    localparam logic [1:0] S_DONE   = 2'd3;

    localparam logic [4:0] STEP_MV0  = 5'd10;
    localparam logic [4:0] STEP_POS0 = 5'd19;
    localparam logic [4:0] STEP_POS1 = 5'd20;
    localparam logic [4:0] STEP_POS2 = 5'd21;
    localparam logic [4:0] STEP_ANG  = 5'd22;
    localparam logic [4:0] STEP_FAC  = 5'd23;
    localparam logic [4:0] STEP_SIZE = 5'd24;

    // Input fields
    logic [1:0]         in_func;
    logic [31:0]        in_time;
    logic signed [15:0] in_qw, in_qx, in_qy, in_qz;
    logic               s_acc;
    logic               tick_live;
    logic [31:0]        el_left;

    // Configuration
    logic signed [31:0] r_vel_x, r_vel_y, r_vel_z, r_angvel;

    // Particle state
    logic               r_active;
    logic [31:0]        r_te, r_el;
    logic [31:0]        r_px, r_py, r_pz;
    logic [31:0]        r_angle, r_is, r_grow, r_size;
    logic [15:0]        r_alpha;

    // Sequencer and output
    logic [1:0]         r_state;
    logic [4:0]         r_step;
    logic               r_div_done;
    logic               r_ovalid;
    logic [183:0]       r_odata;
    logic               out_free;

    // Working registers of a tick
    logic [31:0]        r_dt;
    logic signed [15:0] r_qw, r_qx, r_qy, r_qz;
    logic signed [31:0] r_qp [10];
    logic signed [53:0] r_racc;
    logic signed [39:0] r_rot [3];
    logic [FRAC_BITS:0] r_life;
    logic [31:0]        r_factor;

    // Shared units
    logic                     mul_start, mul_done;
    logic signed [MUL_AW-1:0] mul_a;
    logic signed [MUL_BW-1:0] mul_b;
    logic [PW-1:0]            mul_prod;
    logic                     div_start, div_done;
    logic [DIV_QW-1:0]        div_quot;

    // Datapath helpers
    t_pair              qpair;
    logic [3:0]         mv_idx;
    logic [3:0]         rowcol;
    logic signed [15:0] q_a, q_b;
    logic signed [35:0] s_term, m_full;
    logic signed [20:0] m_red;
    logic signed [31:0] v_sel;
    logic signed [53:0] p_mv, racc_next;
    logic [31:0]        scaled;
    logic [FW-1:0]      fac_sum;
    logic               size_sat;
    logic [1:0]         pos_idx;

    assign in_func   = i_s_axis_tuser;
    assign in_time   = i_s_axis_tdata[31:0];
    assign in_qw     = i_s_axis_tdata[47:32];
    assign in_qx     = i_s_axis_tdata[63:48];
    assign in_qy     = i_s_axis_tdata[79:64];
    assign in_qz     = i_s_axis_tdata[95:80];

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_acc     = i_s_axis_tvalid && o_s_axis_tready;
    assign tick_live = (in_func == FUNC_TICK) && r_active && (in_time < r_el);
    assign el_left   = r_el - in_time;
    assign div_start = s_acc && tick_live;
    assign out_free  = !r_ovalid || i_m_axis_tready;

    plu_mul #(
        .AW (MUL_AW),
        .BW (MUL_BW),
        .DW (MUL_DW)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    plu_div #(
        .QW (DIV_QW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (el_left),
        .i_den   (r_te),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Pick the quaternion components for the current product
    always_comb begin
        qpair = plu_qpair(r_step[3:0]);
        case (qpair[3:2])
            QC_W:    q_a = r_qw;
            QC_X:    q_a = r_qx;
            QC_Y:    q_a = r_qy;
            default: q_a = r_qz;
        endcase
        case (qpair[1:0])
            QC_W:    q_b = r_qw;
            QC_X:    q_b = r_qx;
            QC_Y:    q_b = r_qy;
            default: q_b = r_qz;
        endcase
    end

    // Form one rotation matrix entry from the stored products
    always_comb begin
        mv_idx = 4'(r_step - STEP_MV0);
        rowcol = plu_rowcol(mv_idx);
        s_term = 36'(r_qp[0]) - 36'(r_qp[1]) - 36'(r_qp[2]) - 36'(r_qp[3]);
        case (mv_idx)
            4'd0:    m_full = s_term + 2 * 36'(r_qp[1]);
            4'd1:    m_full = 2 * 36'(r_qp[4]) - 2 * 36'(r_qp[9]);
            4'd2:    m_full = 2 * 36'(r_qp[5]) + 2 * 36'(r_qp[8]);
            4'd3:    m_full = 2 * 36'(r_qp[4]) + 2 * 36'(r_qp[9]);
            4'd4:    m_full = s_term + 2 * 36'(r_qp[2]);
            4'd5:    m_full = 2 * 36'(r_qp[6]) - 2 * 36'(r_qp[7]);
            4'd6:    m_full = 2 * 36'(r_qp[5]) - 2 * 36'(r_qp[8]);
            4'd7:    m_full = 2 * 36'(r_qp[6]) + 2 * 36'(r_qp[7]);
            4'd8:    m_full = s_term + 2 * 36'(r_qp[3]);
            default: m_full = '0;
        endcase
        m_red = m_full[34:14];
        case (rowcol[1:0])
            2'd0:    v_sel = r_vel_x;
            2'd1:    v_sel = r_vel_y;
            default: v_sel = r_vel_z;
        endcase
        pos_idx = 2'(r_step - STEP_POS0);
    end

    // Drive the multiplier operands for the current step
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        priority if (r_step < STEP_MV0) begin
            mul_a = MUL_AW'(q_a);
            mul_b = MUL_BW'(q_b);
        end else if (r_step < STEP_POS0) begin
            mul_a = MUL_AW'(m_red);
            mul_b = MUL_BW'(v_sel);
        end else if (r_step < STEP_ANG) begin
            mul_a = MUL_AW'(r_rot[pos_idx]);
            mul_b = MUL_BW'(r_dt);
        end else if (r_step == STEP_ANG) begin
            mul_a = MUL_AW'(r_angvel);
            mul_b = MUL_BW'(r_dt);
        end else if (r_step == STEP_FAC) begin
            mul_a = MUL_AW'(r_grow);
            mul_b = MUL_BW'(LIFE_ONE - r_life);
        end else begin
            mul_a = MUL_AW'(r_is);
            mul_b = MUL_BW'(r_factor);
        end
    end

    // Results of the finished product
    always_comb begin
        p_mv      = mul_prod[53:0];
        racc_next = (rowcol[1:0] == 2'd0) ? p_mv : (r_racc + p_mv);
        scaled    = mul_prod[FRAC_BITS+31 -: 32];
        fac_sum   = mul_prod[FW-1:0] + FW'({r_life, {FRAC_BITS{1'b0}}});
        size_sat  = |mul_prod[63:FRAC_BITS+32];
        mul_start = (r_state == S_MSTART) && ((r_step != STEP_FAC) || r_div_done);
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vel_x  <= '0;
            r_vel_y  <= '0;
            r_vel_z  <= '0;
            r_angvel <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_VEL_X:   r_vel_x  <= i_cfg_data;
                CFG_VEL_Y:   r_vel_y  <= i_cfg_data;
                CFG_VEL_Z:   r_vel_z  <= i_cfg_data;
                CFG_ANG_VEL: r_angvel <= i_cfg_data;
            endcase
        end
    end

    // Sequencer and particle state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_step     <= '0;
            r_div_done <= 1'b0;
            r_ovalid   <= 1'b0;
            r_active   <= 1'b0;
            r_te       <= '0;
            r_el       <= '0;
            r_px       <= '0;
            r_py       <= '0;
            r_pz       <= '0;
            r_angle    <= '0;
            r_is       <= '0;
            r_grow     <= '0;
            r_size     <= '0;
            r_alpha    <= '0;
        end else begin
            // Mark the output register full when an item finishes; release it once taken
            if (r_state == S_DONE && out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end

            if (div_start) begin
                r_div_done <= 1'b0;
            end else if (div_done) begin
                r_div_done <= 1'b1;
                if (r_te == '0) begin
                    r_alpha <= '0;
                end else begin
                    r_alpha <= div_quot[DIV_K-ALPHA_SHIFT +: 16];
                end
            end

            unique case (r_state)
                S_IDLE: begin
                    if (s_acc) begin
                        r_state <= S_DONE;
                        priority if (in_func == FUNC_SPAWN) begin
                            r_active <= 1'b1;
                            r_te     <= in_time;
                            r_el     <= in_time;
                            r_px     <= i_s_axis_tdata[127:96];
                            r_py     <= i_s_axis_tdata[159:128];
                            r_pz     <= i_s_axis_tdata[191:160];
                            r_is     <= i_s_axis_tdata[223:192];
                            r_size   <= i_s_axis_tdata[223:192];
                            r_grow   <= i_s_axis_tdata[255:224];
                            r_angle  <= i_s_axis_tdata[287:256];
                            r_alpha  <= ALPHA_FULL;
                        end else if (in_func == FUNC_KILL) begin
                            r_active <= 1'b0;
                        end else if (tick_live) begin
                            r_el    <= el_left;
                            r_step  <= '0;
                            r_state <= S_MSTART;
                        end else if (in_func == FUNC_TICK && r_active) begin
                            // energy used up
                            r_el     <= '0;
                            r_active <= 1'b0;
                        end
                    end
                end
                S_MSTART: begin
                    if (mul_start) begin
                        r_state <= S_MWAIT;
                    end
                end
                S_MWAIT: begin
                    if (mul_done) begin
                        if (r_step == STEP_POS0) r_px <= r_px + scaled;
                        if (r_step == STEP_POS1) r_py <= r_py + scaled;
                        if (r_step == STEP_POS2) r_pz <= r_pz + scaled;
                        if (r_step == STEP_ANG)  r_angle <= r_angle + scaled;
                        if (r_step == STEP_SIZE) begin
                            r_size  <= size_sat ? 32'hFFFF_FFFF : scaled;
                            r_state <= S_DONE;
                        end else begin
                            r_step  <= r_step + 1'b1;
                            r_state <= S_MSTART;
                        end
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
            endcase
        end
    end

    // Working registers of a tick
    always_ff @(posedge i_clk) begin
        if (div_start) begin
            r_dt <= in_time;
            r_qw <= in_qw;
            r_qx <= in_qx;
            r_qy <= in_qy;
            r_qz <= in_qz;
        end
        if (div_done) begin
            r_life <= (r_te == '0) ? '0 : div_quot[DIV_K-FRAC_BITS +: FRAC_BITS+1];
        end
        if (r_state == S_MWAIT && mul_done) begin
            priority if (r_step < STEP_MV0) begin
                r_qp[r_step[3:0]] <= mul_prod[31:0];
            end else if (r_step < STEP_POS0) begin
                r_racc <= racc_next;
                if (rowcol[1:0] == 2'd2) begin
                    r_rot[rowcol[3:2]] <= racc_next[53:14];
                end
            end else if (r_step == STEP_FAC) begin
                r_factor <= fac_sum[FRAC_BITS+31 -: 32];
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_odata <= {7'd0, r_size, r_angle, r_alpha, r_pz, r_py, r_px, r_active};
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;

    `PLU_ASSERT(a_energy_order, r_el <= r_te)
    `PLU_ASSERT(a_alpha_max, r_alpha <= ALPHA_FULL)
    `PLU_ASSERT_IMPL(a_fac_after_div, mul_start && r_step == STEP_FAC, r_div_done)
    `PLU_ASSERT_NEXT(a_kill_clears, s_acc && in_func == FUNC_KILL, !r_active)

endmodule
